// File: rtl/wfc_pkg.sv
// Shared types and constants for the word frequency counter.
// Holds character codes, item codes, default sizes and the status struct
// that passes from the word buffer to the top level. No dependencies.
`timescale 1ns / 1ps

package wfc_pkg;

    localparam int MAX_WORDS_DEF      = 32;
    localparam int MAX_WORD_CHARS_DEF = 16;
    localparam int COUNT_BITS_DEF     = 16;

    localparam int SLOT_W  = 5;
    localparam int COUNT_W = 16;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_PERIOD   = 8'h2E;
    localparam logic [7:0] CH_UPPER_A  = 8'd65;
    localparam logic [7:0] CH_UPPER_Z  = 8'd90;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    typedef struct packed {
        logic close;
        logic empty;
        logic overflow;
    } t_buf_stat;

endpackage

// File: rtl/word_frequency_counter_top.sv
// Top level of the word frequency counter: word table memory, lookup
// sequencer and result register. Depends on wfc_pkg and wfc_word_buf.
`timescale 1ns / 1ps

// An ordinary character, colon or comma request is taken without a stall. A
// request that closes a non-empty word starts a lookup that reads one table
// row per cycle from the single read port of the word table memory: the
// input stalls while stored entries are compared in order, up to the entry
// that the word matches or, when it is new or dropped, through all stored
// entries. A result waits in an output register while further characters
// are accepted; if the previous result is still stalled there when a
// lookup ends, the input stays stalled until that result is taken.
module word_frequency_counter_top import wfc_pkg::*; #(
    parameter int MAX_WORDS      = MAX_WORDS_DEF,
    parameter int MAX_WORD_CHARS = MAX_WORD_CHARS_DEF,
    parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [7:0]         i_ch,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [SLOT_W-1:0]  o_slot,
    output logic [COUNT_W-1:0] o_count,
    output logic               o_new_word,
    output logic               o_table_full,
    output logic               o_truncated
);

    localparam int LEN_W = $clog2(MAX_WORD_CHARS + 1);
    localparam int IX_W  = $clog2(MAX_WORDS);
    localparam int CTR_W = IX_W + 1;

    typedef struct packed {
        logic [MAX_WORD_CHARS-1:0][7:0] chars;
        logic [LEN_W-1:0]               len;
        logic [COUNT_BITS-1:0]          cnt;
    } t_row;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_row   r_mem [MAX_WORDS];
    t_row   r_rd_row;

    t_state                r_state;
    logic [CTR_W-1:0]      r_idx;
    logic [CTR_W-1:0]      r_cmp_idx;
    logic                  r_cmp_vld;
    logic [CTR_W-1:0]      r_total;
    logic [IX_W-1:0]       r_res_slot;
    logic [COUNT_BITS-1:0] r_res_cnt;
    logic                  r_res_new;
    logic                  r_res_full;
    logic                  r_res_trunc;
    logic                  r_out_valid;
    logic [SLOT_W-1:0]     r_slot;
    logic [COUNT_W-1:0]    r_count;
    logic                  r_new_word;
    logic                  r_table_full;
    logic                  r_truncated;

    logic [MAX_WORD_CHARS-1:0][7:0] w_chars;
    logic [LEN_W-1:0]               w_len;
    t_buf_stat                      w_stat;
    logic                           w_take;
    logic                           w_clear;
    logic                           w_match;
    logic                           w_miss;
    logic                           w_room;
    logic                           w_we;
    logic [IX_W-1:0]                w_waddr;
    t_row                           w_wdata;
    logic [COUNT_BITS-1:0]          n_cnt;
    logic                           w_out_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_take     = i_in_valid && !o_in_stall;

    wfc_word_buf #(
        .MAX_WORD_CHARS(MAX_WORD_CHARS)
    ) u_word_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_op    (i_op),
        .i_ch    (i_ch),
        .i_clear (w_clear),
        .o_chars (w_chars),
        .o_len   (w_len),
        .o_stat  (w_stat)
    );

    always_comb begin
        w_match = (r_rd_row.len == w_len);
        for (int i = 0; i < MAX_WORD_CHARS; i++) begin
            if (LEN_W'(i) < w_len && r_rd_row.chars[i] != w_chars[i]) begin
                w_match = 1'b0;
            end
        end
    end

    always_comb begin
        w_miss  = (r_state == S_SCAN) && r_cmp_vld && (r_cmp_idx == r_total);
        w_room  = (r_total < CTR_W'(MAX_WORDS));
        n_cnt   = (&r_rd_row.cnt) ? r_rd_row.cnt : r_rd_row.cnt + COUNT_BITS'(1);
        w_we    = 1'b0;
        w_waddr = r_cmp_idx[IX_W-1:0];
        w_wdata = r_rd_row;
        if (w_miss) begin
            w_we          = w_room;
            w_waddr       = r_total[IX_W-1:0];
            w_wdata.chars = w_chars;
            w_wdata.len   = w_len;
            w_wdata.cnt   = COUNT_BITS'(1);
        end else if (r_state == S_SCAN && r_cmp_vld && w_match) begin
            w_we        = 1'b1;
            w_wdata.cnt = n_cnt;
        end
    end

    assign w_clear    = w_we || w_miss;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_row <= r_mem[r_idx[IX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_cmp_idx   <= '0;
            r_cmp_vld   <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_stat.close && !w_stat.empty) begin
                        r_state   <= S_SCAN;
                        r_idx     <= '0;
                        r_cmp_vld <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_cmp_vld   <= 1'b1;
                    r_cmp_idx   <= r_idx;
                    r_idx       <= r_idx + CTR_W'(1);
                    r_res_trunc <= w_stat.overflow;
                    if (w_miss) begin
                        r_state    <= S_DONE;
                        r_res_new  <= w_room;
                        r_res_full <= !w_room;
                        r_res_slot <= w_room ? r_total[IX_W-1:0] : '0;
                        r_res_cnt  <= w_room ? COUNT_BITS'(1) : '0;
                        if (w_room) begin
                            r_total <= r_total + CTR_W'(1);
                        end
                    end else if (w_we) begin
                        r_state    <= S_DONE;
                        r_res_new  <= 1'b0;
                        r_res_full <= 1'b0;
                        r_res_slot <= r_cmp_idx[IX_W-1:0];
                        r_res_cnt  <= n_cnt;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state      <= S_IDLE;
                        r_slot       <= SLOT_W'(r_res_slot);
                        r_count      <= COUNT_W'(r_res_cnt);
                        r_new_word   <= r_res_new;
                        r_table_full <= r_res_full;
                        r_truncated  <= r_res_trunc;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_slot       = r_slot;
    assign o_count      = r_count;
    assign o_new_word   = r_new_word;
    assign o_table_full = r_table_full;
    assign o_truncated  = r_truncated;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CTR_W'(MAX_WORDS))
        else $error("Table entry total exceeds the table size.");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> w_len != '0)
        else $error("Lookup runs on an empty word.");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_table_full |-> !o_new_word && o_slot == '0 && o_count == '0)
        else $error("Dropped word carries a slot or count.");

    a_new_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_new_word |-> o_count == COUNT_W'(1))
        else $error("New word does not start at count one.");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_miss && w_room |=> r_total == $past(r_total) + CTR_W'(1))
        else $error("Insertion did not advance the entry total.");

endmodule

// File: rtl/wfc_word_buf.sv
// Character front end of the word frequency counter: classifies each
// request, folds case and collects the current word. Depends on wfc_pkg.
`timescale 1ns / 1ps

module wfc_word_buf import wfc_pkg::*; #(
    parameter int MAX_WORD_CHARS = MAX_WORD_CHARS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_take,
    input  logic                                     i_op,
    input  logic [7:0]                               i_ch,
    input  logic                                     i_clear,
    output logic [MAX_WORD_CHARS-1:0][7:0]           o_chars,
    output logic [$clog2(MAX_WORD_CHARS+1)-1:0]      o_len,
    output t_buf_stat                                o_stat
);

    localparam int LEN_W = $clog2(MAX_WORD_CHARS + 1);
    localparam int IX_W  = $clog2(MAX_WORD_CHARS);

    logic [MAX_WORD_CHARS-1:0][7:0] r_chars;
    logic [LEN_W-1:0]               r_len;
    logic                           r_ovf;
    logic                           w_drop;
    logic                           w_sep;
    logic [7:0]                     w_folded;

    always_comb begin
        w_drop   = 1'b0;
        w_sep    = 1'b0;
        w_folded = i_ch;
        if (i_op == OP_EOL) begin
            w_sep = 1'b1;
        end else begin
            w_drop = i_ch inside {CH_COLON, CH_COMMA};
            w_sep  = i_ch inside {CH_SPACE, CH_PERIOD};
            if (i_ch inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
                w_folded = i_ch + CASE_OFFSET;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_ovf <= 1'b0;
        end else if (i_clear) begin
            r_len <= '0;
            r_ovf <= 1'b0;
        end else if (i_take) begin
            if (w_sep) begin
                if (r_len == '0) begin
                    r_ovf <= 1'b0;
                end
            end else if (!w_drop) begin
                if (r_len < LEN_W'(MAX_WORD_CHARS)) begin
                    r_len <= r_len + LEN_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && !w_sep && !w_drop && r_len < LEN_W'(MAX_WORD_CHARS)) begin
            r_chars[r_len[IX_W-1:0]] <= w_folded;
        end
    end

    assign o_chars        = r_chars;
    assign o_len          = r_len;
    assign o_stat.close    = i_take && w_sep;
    assign o_stat.empty    = (r_len == '0);
    assign o_stat.overflow = r_ovf;

endmodule
